### rtl/core/cdalu_pkg.sv
`default_nettype none
package cdalu_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int UNITS = 6;
    localparam int LANES = 8;

    localparam int U_YEARS   = 0;
    localparam int U_MONTHS  = 1;
    localparam int U_WEEKS   = 2;
    localparam int U_DAYS    = 3;
    localparam int U_HOURS   = 4;
    localparam int U_MINUTES = 5;

    localparam int LANE_MONTHS  = 6;
    localparam int LANE_MINUTES = 7;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int MIN_PER_WEEK    = 10080;
    localparam int MIN_PER_DAY     = 1440;
    localparam int MIN_PER_HOUR    = 60;

    localparam logic [1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [1:0] ORDER_GREATER = 2'b01;
    localparam logic [1:0] ORDER_LESS    = 2'b11;

    localparam logic [0:0] REG_MAX_VALUE = 1'b0;

endpackage
`default_nettype wire

### rtl/core/calendar_duration_alu.sv
// Calendar duration ALU.
// s_axis: one beat carries durations A and B (six unit counts each).
// m_axis: one beat per input beat with the wrapped per-unit sums, the
//   ordering of A against B, the multiple flag and the operand error flag.
// APB: register max_value at byte address 0 (wrap modulus and legal limit).
// Throughput: one beat per cycle while m_tready is high. The pipeline is
// an input stage, a totals stage and the bit-per-stage remainder pipeline
// that divides the duration totals (VALUE_BITS + 14 stages).
// Every stage holds its beat while the stage ahead is full, so a stall on
// m_tready fills the pipeline up and only then drops s_tready; nothing is
// lost or repeated.
// Reset clears all valid bits and loads max_value with 65535.
// Write max_value only while no beat is in flight.
`default_nettype none
module calendar_duration_alu
    import cdalu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // a_years, a_months, a_weeks, a_days, a_hours, a_minutes,
    // b_years, b_months, b_weeks, b_days, b_hours, b_minutes
    input  wire logic [((12*VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // sum_years .. sum_minutes, order, a_multiple_of_b, bad_operand
    output logic [((6*VALUE_BITS+4+7)/8)*8-1:0] m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int V   = VALUE_BITS;
    localparam int SW  = V + 1;
    localparam int TW  = V + 14;
    localparam int D   = TW;
    localparam int IW  = 12 * V;

    typedef struct packed {
        logic [TW-1:0] num;
        logic [TW-1:0] rem;
        logic [TW-1:0] den;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0]         lane;
        logic [UNITS-1:0][SW-1:0]  sum;
        logic [1:0]                order;
        logic                      zero_mo;
        logic                      zero_mi;
        logic                      bad;
    } pipe_t;

    function automatic lane_t div_step(input lane_t x);
        logic [TW:0] t;
        lane_t       y;
        t = {x.rem, x.num[TW-1]};
        y = x;
        y.num = {x.num[TW-2:0], 1'b0};
        if (t >= {1'b0, x.den}) begin
            y.rem = TW'(t - {1'b0, x.den});
        end else begin
            y.rem = t[TW-1:0];
        end
        return y;
    endfunction

    // configuration
    logic [V-1:0] max_value_reg;
    logic [V-1:0] m_eff;

    assign pready = 1'b1;
    assign m_eff  = (max_value_reg == '0) ? V'(1) : max_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= V'(65535);
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_VALUE) begin
            max_value_reg <= pwdata[V-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_VALUE) begin
            prdata[V-1:0] = max_value_reg;
        end
    end

    // input stage
    logic [IW-1:0] in_reg;
    logic          in_v_reg;
    logic          in_rdy;
    logic          rdy [0:D];
    logic          pv_reg [0:D];
    pipe_t         pipe_reg [0:D];

    assign in_rdy   = !in_v_reg || rdy[0];
    assign s_tready = in_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_rdy) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            in_reg <= s_tdata[IW-1:0];
        end
    end

    // totals stage
    pipe_t            p0_next;
    logic [V-1:0]     a_u [UNITS];
    logic [V-1:0]     b_u [UNITS];
    logic [TW-1:0]    tm_a, tm_b, tn_a, tn_b;
    logic             bad_any;

    always_comb begin
        bad_any = 1'b0;
        for (int i = 0; i < UNITS; i++) begin
            a_u[i] = in_reg[i*V +: V];
            b_u[i] = in_reg[(UNITS+i)*V +: V];
            if (a_u[i] > m_eff || b_u[i] > m_eff) begin
                bad_any = 1'b1;
            end
        end
        tm_a = TW'(a_u[U_YEARS]) * TW'(MONTHS_PER_YEAR) + TW'(a_u[U_MONTHS]);
        tm_b = TW'(b_u[U_YEARS]) * TW'(MONTHS_PER_YEAR) + TW'(b_u[U_MONTHS]);
        tn_a = TW'(a_u[U_WEEKS]) * TW'(MIN_PER_WEEK) + TW'(a_u[U_DAYS]) * TW'(MIN_PER_DAY)
             + TW'(a_u[U_HOURS]) * TW'(MIN_PER_HOUR) + TW'(a_u[U_MINUTES]);
        tn_b = TW'(b_u[U_WEEKS]) * TW'(MIN_PER_WEEK) + TW'(b_u[U_DAYS]) * TW'(MIN_PER_DAY)
             + TW'(b_u[U_HOURS]) * TW'(MIN_PER_HOUR) + TW'(b_u[U_MINUTES]);

        p0_next = '0;
        for (int i = 0; i < UNITS; i++) begin
            p0_next.sum[i]      = SW'(a_u[i]) + SW'(b_u[i]);
            p0_next.lane[i].num = TW'(p0_next.sum[i]);
            p0_next.lane[i].den = TW'(m_eff);
        end
        p0_next.lane[LANE_MONTHS].num  = tm_a;
        p0_next.lane[LANE_MONTHS].den  = tm_b;
        p0_next.lane[LANE_MINUTES].num = tn_a;
        p0_next.lane[LANE_MINUTES].den = tn_b;
        p0_next.zero_mo = (tm_a == '0);
        p0_next.zero_mi = (tn_a == '0);
        p0_next.bad     = bad_any;
    end

    assign rdy[D] = m_tready || !pv_reg[D];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            pv_reg[0] <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            pipe_reg[0] <= p0_next;
        end
    end

    // remainder stages, one numerator bit each
    for (genvar k = 1; k <= D; k++) begin : g_div
        pipe_t step_next;

        assign rdy[k-1] = !pv_reg[k-1] || rdy[k];

        always_comb begin
            step_next = pipe_reg[k-1];
            for (int l = 0; l < LANES; l++) begin
                step_next.lane[l] = div_step(pipe_reg[k-1].lane[l]);
            end
            if (k == 1) begin
                priority if (pipe_reg[0].lane[LANE_MONTHS].num >
                             pipe_reg[0].lane[LANE_MONTHS].den) begin
                    step_next.order = ORDER_GREATER;
                end else if (pipe_reg[0].lane[LANE_MONTHS].num <
                             pipe_reg[0].lane[LANE_MONTHS].den) begin
                    step_next.order = ORDER_LESS;
                end else if (pipe_reg[0].lane[LANE_MINUTES].num >
                             pipe_reg[0].lane[LANE_MINUTES].den) begin
                    step_next.order = ORDER_GREATER;
                end else if (pipe_reg[0].lane[LANE_MINUTES].num <
                             pipe_reg[0].lane[LANE_MINUTES].den) begin
                    step_next.order = ORDER_LESS;
                end else begin
                    step_next.order = ORDER_EQUAL;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pv_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                pipe_reg[k] <= step_next;
            end
        end
    end

    // output select
    pipe_t last;
    logic  mult_mo, mult_mi;

    assign last    = pipe_reg[D];
    assign mult_mo = (last.lane[LANE_MONTHS].den == '0) ? last.zero_mo
                                                       : (last.lane[LANE_MONTHS].rem == '0);
    assign mult_mi = (last.lane[LANE_MINUTES].den == '0) ? last.zero_mi
                                                        : (last.lane[LANE_MINUTES].rem == '0);

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < UNITS; i++) begin
            if (last.sum[i] > SW'(m_eff)) begin
                m_tdata[i*V +: V] = last.lane[i].rem[V-1:0];
            end else begin
                m_tdata[i*V +: V] = last.sum[i][V-1:0];
            end
        end
        m_tdata[6*V +: 2] = last.order;
        m_tdata[6*V+2]    = mult_mo && mult_mi;
        m_tdata[6*V+3]    = last.bad;
    end

    assign m_tvalid = pv_reg[D];

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6*V +: 2] != 2'b10)
        else $error("order code out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_v_reg && rdy[0]) |=> pv_reg[0])
        else $error("beat dropped entering totals stage");

endmodule
`default_nettype wire
